// ----- rtl/sha256_stream_hasher_unit_assert.svh -----
// ----------------------------------------------------------------------------
// SHA-256 stream hasher assertion macros
// Clocked assertion shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_UNIT_ASSERT_SVH
`define SHA256_STREAM_HASHER_UNIT_ASSERT_SVH

// Assertion on an explicit clock and active-low reset.
`define SHA256_ASSERT_CR(name, clock, resetn, prop, msg) \
    name: assert property (@(posedge clock) disable iff (!resetn) prop) \
        else $error(msg);

// Assertion on the checker's own clk and rst_n.
`define SHA256_ASSERT(name, prop, msg) \
    `SHA256_ASSERT_CR(name, clk, rst_n, prop, msg)

`endif

// ----- rtl/sha256_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-256 package
// Constants, round functions and the control bundle shared by the hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam int unsigned HashWords  = 8;
    localparam int unsigned SchedWords = 16;
    localparam int unsigned Rounds     = 64;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [31:0] INIT_HASH [HashWords] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [Rounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Control bundle from the sequencer to the schedule and round units.
    typedef struct packed {
        logic       pack_en;
        logic       round_en;
        logic       hash_add;
        logic       hash_init;
        logic [5:0] round_idx;
    } ctrl_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ----- rtl/sha256_sched.sv -----
// ----------------------------------------------------------------------------
// SHA-256 message schedule
// Packs bytes big-endian into sixteen words and expands them during rounds.
// ----------------------------------------------------------------------------
module sha256_sched (
    input  logic                clk,
    input  sha256_pkg::ctrl_t   ctrl,
    input  logic [7:0]          pack_byte,
    input  logic [5:0]          pack_pos,
    output logic [31:0]         sched_word
);
    import sha256_pkg::*;

    logic [31:0] w_reg [SchedWords];
    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic [31:0] expand_word;

    // A byte at the first position of a word starts that word from zero.
    always_comb
    begin
        acc_next = ((pack_pos[1:0] == 2'd0) ? 32'h0 : acc_reg)
                 | ({24'h0, pack_byte} << {~pack_pos[1:0], 3'b000});
    end

    // The window holds W[j] .. W[j+15]; this forms W[j+16].
    assign expand_word = small_sigma1(w_reg[14]) + w_reg[9]
                       + small_sigma0(w_reg[1]) + w_reg[0];

    always_ff @(posedge clk)
    begin
        if (ctrl.pack_en)
        begin
            acc_reg                <= acc_next;
            w_reg[pack_pos[5:2]]   <= acc_next;
        end
        else if (ctrl.round_en)
        begin
            for (int i = 0; i < SchedWords - 1; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[SchedWords - 1] <= expand_word;
        end
    end

    assign sched_word = w_reg[0];

endmodule

// ----- rtl/sha256_round.sv -----
// ----------------------------------------------------------------------------
// SHA-256 round unit
// Working variables, hash words and the one-round-per-cycle compression step.
// ----------------------------------------------------------------------------
module sha256_round (
    input  logic                clk,
    input  logic                rst_n,
    input  sha256_pkg::ctrl_t   ctrl,
    input  logic [31:0]         sched_word,
    input  logic [2:0]          read_idx,
    output logic [31:0]         hash_word
);
    import sha256_pkg::*;

    logic [31:0] work_reg [HashWords];
    logic [31:0] hash_reg [HashWords];
    logic [31:0] sum_word [HashWords];
    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] t1;
    logic [31:0] t2;

    always_comb
    begin
        ch  = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
        maj = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
            ^ (work_reg[1] & work_reg[2]);
        t1  = work_reg[7] + big_sigma1(work_reg[4]) + ch
            + ROUND_K[ctrl.round_idx] + sched_word;
        t2  = big_sigma0(work_reg[0]) + maj;
        for (int i = 0; i < HashWords; i++)
        begin
            sum_word[i] = hash_reg[i] + work_reg[i];
        end
    end

    // The working words always leave a block equal to the new hash words,
    // so the next block starts without a separate load cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HashWords; i++)
            begin
                hash_reg[i] <= INIT_HASH[i];
                work_reg[i] <= INIT_HASH[i];
            end
        end
        else
        begin
            priority if (ctrl.hash_init)
            begin
                for (int i = 0; i < HashWords; i++)
                begin
                    hash_reg[i] <= INIT_HASH[i];
                    work_reg[i] <= INIT_HASH[i];
                end
            end
            else if (ctrl.hash_add)
            begin
                for (int i = 0; i < HashWords; i++)
                begin
                    hash_reg[i] <= sum_word[i];
                    work_reg[i] <= sum_word[i];
                end
            end
            else if (ctrl.round_en)
            begin
                work_reg[7] <= work_reg[6];
                work_reg[6] <= work_reg[5];
                work_reg[5] <= work_reg[4];
                work_reg[4] <= work_reg[3] + t1;
                work_reg[3] <= work_reg[2];
                work_reg[2] <= work_reg[1];
                work_reg[1] <= work_reg[0];
                work_reg[0] <= t1 + t2;
            end
        end
    end

    assign hash_word = hash_reg[read_idx];

endmodule

// ----- rtl/sha256_stream_hasher_unit.sv -----
// ----------------------------------------------------------------------------
// SHA-256 stream hasher: one byte per item, eight digest words per message.
// A byte item that completes a 64-byte block starts its compression: 64 rounds, then 1 add.
// End of message: padding is packed byte by byte, one or two compressions follow, then 8 words.
// A byte that completes a block holds off new items until the single shared round unit is done.
// Asynchronous active-low reset loads the initial hash and clears the byte count.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import sha256_pkg::*;

    // Sequencer states. The block takes a new item only in the idle state.
    // Padding runs byte by byte through the same packing path as message
    // bytes, so the schedule unit needs no separate padding logic.
    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_COMP     = 7'b0000010,
        ST_ADD      = 7'b0000100,
        ST_PAD_ONE  = 7'b0001000,
        ST_PAD_ZERO = 7'b0010000,
        ST_PAD_LEN  = 7'b0100000,
        ST_OUT      = 7'b1000000
    } state_t;

    localparam logic [5:0] BLOCK_END = 6'd63;   // last byte position of a block
    localparam logic [5:0] LEN_PREV  = 6'd55;   // position just before the length field
    localparam logic [2:0] LAST_IDX  = 3'd7;

    state_t       state_reg;
    state_t       state_next;
    state_t       ret_reg;
    state_t       ret_next;
    logic [5:0]   pos_reg;
    logic [5:0]   pos_next;
    logic [60:0]  count_reg;
    logic [60:0]  count_next;
    logic [5:0]   round_reg;
    logic [5:0]   round_next;
    logic [2:0]   idx_reg;
    logic [2:0]   idx_next;
    logic         out_valid_reg;
    logic [31:0]  digest_reg;
    logic [2:0]   index_reg;
    logic         last_reg;
    logic         out_load;

    ctrl_t        ctrl;
    logic [7:0]   pack_byte;
    logic [31:0]  sched_word;
    logic [31:0]  hash_word;
    logic [63:0]  len_bits;
    logic [7:0]   len_byte;

    // The length field is the message byte count times eight, sent most
    // significant byte first in positions 56 to 63 of the final block.
    assign len_bits = {count_reg, 3'b000};
    assign len_byte = 8'(len_bits >> {~pos_reg[2:0], 3'b000});

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        round_next     = round_reg;
        idx_next       = idx_reg;
        out_load       = 1'b0;
        pack_byte      = data_byte;
        ctrl           = '0;
        ctrl.round_idx = round_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                // A byte in the same item as the end mark is taken first.
                if (in_valid)
                begin
                    if (has_byte)
                    begin
                        ctrl.pack_en = 1'b1;
                        pos_next     = pos_reg + 6'd1;
                        count_next   = count_reg + 61'd1;
                        if (pos_reg == BLOCK_END)
                        begin
                            state_next = ST_COMP;
                            if (last_byte)
                            begin
                                ret_next = ST_PAD_ONE;
                            end
                            else
                            begin
                                ret_next = ST_IDLE;
                            end
                        end
                        else if (last_byte)
                        begin
                            state_next = ST_PAD_ONE;
                        end
                    end
                    else if (last_byte)
                    begin
                        state_next = ST_PAD_ONE;
                    end
                end
            end
            ST_PAD_ONE, ST_PAD_ZERO:
            begin
                // The marker byte carries the single 1 bit; zeros follow until
                // the length field. A full block on the way is compressed first.
                ctrl.pack_en = 1'b1;
                pack_byte    = (state_reg == ST_PAD_ONE) ? PAD_MARK : 8'h00;
                pos_next     = pos_reg + 6'd1;
                if (pos_reg == BLOCK_END)
                begin
                    state_next = ST_COMP;
                    ret_next   = ST_PAD_ZERO;
                end
                else if (pos_reg == LEN_PREV)
                begin
                    state_next = ST_PAD_LEN;
                end
                else
                begin
                    state_next = ST_PAD_ZERO;
                end
            end
            ST_PAD_LEN:
            begin
                ctrl.pack_en = 1'b1;
                pack_byte    = len_byte;
                pos_next     = pos_reg + 6'd1;
                if (pos_reg == BLOCK_END)
                begin
                    state_next = ST_COMP;
                    ret_next   = ST_OUT;
                end
            end
            ST_COMP:
            begin
                // One round per cycle through the shared round unit.
                ctrl.round_en = 1'b1;
                round_next    = round_reg + 6'd1;
                if (round_reg == BLOCK_END)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                ctrl.hash_add = 1'b1;
                state_next    = ret_reg;
            end
            ST_OUT:
            begin
                // Words leave through the output register; once the last one
                // is loaded the hash and count return to their reset values.
                if (!out_valid_reg || out_ready)
                begin
                    out_load = 1'b1;
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == LAST_IDX)
                    begin
                        ctrl.hash_init = 1'b1;
                        count_next     = '0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            pos_reg       <= '0;
            count_reg     <= '0;
            round_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            digest_reg <= hash_word;
            index_reg  <= idx_reg;
            last_reg   <= (idx_reg == LAST_IDX);
        end
    end

    sha256_sched u_sched (
        .clk        (clk),
        .ctrl       (ctrl),
        .pack_byte  (pack_byte),
        .pack_pos   (pos_reg),
        .sched_word (sched_word)
    );

    sha256_round u_round (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .sched_word (sched_word),
        .read_idx   (idx_reg),
        .hash_word  (hash_word)
    );

    // The output register decouples the sink: a new message may start
    // while the final digest word still waits to be taken.
    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign digest_word = digest_reg;
    assign word_index  = index_reg;
    assign last_word   = last_reg;

endmodule

// ----- rtl/sha256_checker.sv -----
// ----------------------------------------------------------------------------
// SHA-256 port checker
// Watches the hasher's ports for handshake and digest sequencing errors.
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_unit_assert.svh"

module sha256_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        last_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] digest_word,
    input  logic [2:0]  word_index,
    input  logic        last_word
);

    // A stalled result item holds its word.
    `SHA256_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(digest_word), "stalled digest item changed")

    // Digest words follow one another in order without a gap.
    `SHA256_ASSERT(a_word_seq, out_valid && out_ready && !last_word |=> out_valid && (word_index == 3'($past(word_index) + 3'd1)), "digest word out of sequence")

    // While the digest is still being sent, no new item is taken.
    `SHA256_ASSERT(a_busy_out, out_valid && !last_word |-> !in_ready, "item taken during digest output")

    // An end mark always starts padding, so the block turns busy.
    `SHA256_ASSERT(a_end_busy, in_valid && in_ready && last_byte |=> !in_ready, "end of message did not start padding")

endmodule

bind sha256_stream_hasher_unit sha256_checker u_sha256_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
);

// ----- bench/sha256_digest_checker.sv -----
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Watches both channels of the stream hasher. Every accepted item runs
// through an independent SHA-256 model. Each digest word that leaves the
// block is compared with the oldest predicted word.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        last_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] digest_word,
    input  logic [2:0]  word_index,
    input  logic        last_word,
    output int          mismatches,
    output int          words_pending,
    output int          words_checked
);

    localparam logic [7:0] PAD_MARKER = 8'h80;
    localparam int unsigned LENGTH_FIELD_POS = 56;
    localparam int unsigned BLOCK_BYTES = 64;

    localparam logic [31:0] CHAIN_SEED [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_KEYS [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        is_last;
    } digest_slot_t;

    logic [31:0]  chain [8];
    logic [31:0]  block_words [16];
    logic [60:0]  byte_total;
    digest_slot_t expected_digest_words [$];

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Bytes land big-endian within their schedule word.
    function automatic void put_byte(input int unsigned pos, input logic [7:0] b);
        block_words[pos / 4][31 - 8 * (pos % 4) -: 8] = b;
    endfunction

    function automatic void compress_block();
        logic [31:0] v [8];
        logic [31:0] w;
        logic [31:0] x15;
        logic [31:0] x2;
        logic [31:0] t1;
        logic [31:0] t2;
        v = chain;
        for (int j = 0; j < 64; j++)
        begin
            if (j < 16)
            begin
                w = block_words[j];
            end
            else
            begin
                x15 = block_words[(j - 15) & 15];
                x2  = block_words[(j - 2) & 15];
                w = block_words[j & 15]
                    + (ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3))
                    + block_words[(j - 7) & 15]
                    + (ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10));
                block_words[j & 15] = w;
            end
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_KEYS[j] + w;
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int k = 7; k > 0; k--)
            begin
                v[k] = v[k - 1];
            end
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int k = 0; k < 8; k++)
        begin
            chain[k] = chain[k] + v[k];
        end
    endfunction

    function automatic void restart_message();
        chain = CHAIN_SEED;
        byte_total = '0;
    endfunction

    // Takes one accepted item; an end mark pads, finishes and queues the digest.
    function automatic void absorb_item(input logic [7:0] b, input logic h, input logic l);
        int unsigned pos;
        logic [63:0] bit_len;
        if (h)
        begin
            put_byte(byte_total[5:0], b);
            byte_total = byte_total + 1'b1;
            if (byte_total[5:0] == 6'd0)
                compress_block();
        end
        if (!l)
            return;
        pos = byte_total[5:0];
        put_byte(pos, PAD_MARKER);
        pos++;
        while (pos != LENGTH_FIELD_POS)
        begin
            if (pos == BLOCK_BYTES)
            begin
                compress_block();
                pos = 0;
            end
            else
            begin
                put_byte(pos, 8'h00);
                pos++;
            end
        end
        bit_len = {byte_total, 3'b000};
        for (int i = 0; i < 8; i++)
        begin
            put_byte(LENGTH_FIELD_POS + i, bit_len[63 - 8 * i -: 8]);
        end
        compress_block();
        for (int i = 0; i < 8; i++)
        begin
            expected_digest_words.push_back('{chain[i], 3'(i), i == 7});
        end
        restart_message();
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("[%0t] digest check failed: %s, expected %h, got %h", $time, what, want, got);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_message();
            for (int i = 0; i < 16; i++)
            begin
                block_words[i] = '0;
            end
            expected_digest_words.delete();
            mismatches = 0;
            words_pending = 0;
            words_checked = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                absorb_item(data_byte, has_byte, last_byte);
            if (out_valid && out_ready)
            begin
                if (expected_digest_words.size() == 0)
                begin
                    report_mismatch("digest word with none expected", '0, digest_word);
                end
                else
                begin
                    digest_slot_t slot;
                    slot = expected_digest_words.pop_front();
                    words_checked++;
                    if (digest_word !== slot.word)
                        report_mismatch("digest_word", slot.word, digest_word);
                    if (word_index !== slot.index)
                        report_mismatch("word_index", slot.index, word_index);
                    if (last_word !== slot.is_last)
                        report_mismatch("last_word", slot.is_last, last_word);
                end
            end
            words_pending = expected_digest_words.size();
        end
    end

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Feeds byte streams with end marks into the hasher under shifting idle and
// stall patterns, while a checker predicts and compares every digest word.
// ----------------------------------------------------------------------------
module testbench;

    // This bound only catches a hung handshake.
    localparam int CYCLE_LIMIT = 400000;
    // After the last digest word, give the block time to show any stray word.
    localparam int DRAIN_CYCLES = 100;
    // Message items per idling phase; ignored items are not counted.
    localparam int PHASE_ITEMS = 56;
    // Each phase opens with a message whose length sits on a padding edge:
    // 55 bytes still fits the length field in one block, 56 needs a second
    // padding block, and 64 fills a block exactly before padding starts.
    localparam int EDGE_LENGTHS [3] = '{55, 56, 64};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        has_byte = 1'b0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    int mismatches;
    int words_pending;
    int words_checked;

    // Percent chance per cycle that the sender holds back an item, and that
    // the receiver stalls a digest word.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    int cycle_count = 0;
    int messages_sent = 0;
    int bytes_sent = 0;
    int phase_items = 0;

    sha256_stream_hasher_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .has_byte    (has_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

    sha256_digest_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .has_byte      (has_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .digest_word   (digest_word),
        .word_index    (word_index),
        .last_word     (last_word),
        .mismatches    (mismatches),
        .words_pending (words_pending),
        .words_checked (words_checked)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // The receiver decides at each falling edge whether it takes a word at
    // the next rising edge. With a zero stall rate it is always ready.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Offers one item. The task is entered and left at a falling edge, so the
    // payload only changes away from the sampling edge. Valid is lowered only
    // when the sender decides to idle, never between two back-to-back items.
    task automatic send_item(input logic [7:0] b, input logic h, input logic l);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        has_byte <= h;
        last_byte <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        if (h || l)
            phase_items++;
        if (h)
            bytes_sent++;
        if (l)
            messages_sent++;
    endtask

    // Sends a whole message of random bytes. The end mark either rides on
    // the final byte or comes as a separate item with no byte; an empty
    // message always takes the separate form. Now and then an item that
    // carries neither a byte nor an end mark is slipped in, which the block
    // must ignore.
    task automatic send_message(input int len);
        logic fold_end;
        fold_end = (len != 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, fold_end && (i == len - 1));
        end
        if (!fold_end)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    initial
    begin
        // Reset is held from the start and released at a falling edge.
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed items, no idling. An idle item on its own does nothing.
        send_item(8'h3c, 1'b0, 1'b0);
        // Empty message: end mark without a byte.
        send_item(8'hff, 1'b0, 1'b1);
        // One-byte messages at both byte extremes, end mark folded and apart.
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        // The classic three-byte "abc" message.
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        // An ignored item in the middle of a message leaves it untouched.
        send_item(8'ha5, 1'b1, 1'b0);
        send_item(8'hc3, 1'b0, 1'b0);
        send_item(8'h5a, 1'b1, 1'b1);

        // Random messages in three idling phases. Most are short; about one
        // in eight runs near one block so the padding edges keep coming up,
        // including 63 bytes and the step past one full block.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 11;
                    recv_stall_pct = 58;
                end
                1:
                begin
                    send_idle_pct = 58;
                    recv_stall_pct = 11;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            phase_items = 0;
            send_message(EDGE_LENGTHS[phase]);
            while (phase_items < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_message($urandom_range(50, 70));
                else
                    send_message($urandom_range(0, 12));
            end
        end
        in_valid <= 1'b0;

        // Wait for every predicted digest word, then watch a while longer.
        while (words_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Hashed %0d messages holding %0d bytes in total.", messages_sent, bytes_sent);
        $display("Compared %0d digest words across three idle and stall patterns.",
                 words_checked);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
